// File: hdl/hcm26_pkg.sv
`default_nettype none
package hcm26_pkg;

  localparam int MATRIX_ORDER  = 3;
  localparam int ALPHABET_SIZE = 26;
  localparam int LETTER_W      = 5;
  localparam int KEY_W         = LETTER_W * MATRIX_ORDER * MATRIX_ORDER;
  localparam int PROD_W        = 2 * LETTER_W;
  localparam int SUM_W         = PROD_W + 1;

  localparam logic [KEY_W-1:0] KEY_RESET  = 45'd20962312099377;
  localparam logic [SUM_W-1:0] COF_OFFSET = SUM_W'(ALPHABET_SIZE * ALPHABET_SIZE);

  // floor(x / 26) estimated as (x * 78) >> 11, low by at most one
  localparam int RECIP       = 78;
  localparam int RECIP_SHIFT = 11;
  localparam int RECIP_W     = SUM_W + 7;

  typedef enum logic [0:0] {
    CFG_KEY_MATRIX = 1'b0,
    CFG_DIRECTION  = 1'b1
  } cfg_index_e;

  typedef logic [MATRIX_ORDER-1:0][LETTER_W-1:0] trigraph_t;

  typedef struct packed {
    logic      valid;
    trigraph_t data;
  } grp_xfer_t;

  typedef struct packed {
    logic             dir;
    logic [KEY_W-1:0] key;
  } cfg_t;

  function automatic logic [LETTER_W-1:0] red5(input logic [LETTER_W-1:0] v);
    logic [LETTER_W-1:0] r;
    r = v;
    if (v >= LETTER_W'(ALPHABET_SIZE)) r = v - LETTER_W'(ALPHABET_SIZE);
    return r;
  endfunction

  function automatic logic [LETTER_W-1:0] mod26(input logic [SUM_W-1:0] x);
    logic [RECIP_W-1:0] p;
    logic [6:0]         q;
    logic [SUM_W:0]     r;
    p = RECIP_W'(x) * RECIP_W'(RECIP);
    q = p[RECIP_W-1:RECIP_SHIFT];
    r = {1'b0, x} - (SUM_W+1)'((SUM_W+1)'(q) * (SUM_W+1)'(ALPHABET_SIZE));
    if (r >= (SUM_W+1)'(ALPHABET_SIZE)) r = r - (SUM_W+1)'(ALPHABET_SIZE);
    return r[LETTER_W-1:0];
  endfunction

  function automatic logic [PROD_W-1:0] mul5(input logic [LETTER_W-1:0] a,
                                             input logic [LETTER_W-1:0] b);
    return PROD_W'(a) * PROD_W'(b);
  endfunction

  // inverse mod 26, zero when none exists
  function automatic logic [LETTER_W-1:0] inv26(input logic [LETTER_W-1:0] d);
    logic [LETTER_W-1:0] r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/hcm26_front.sv
`default_nettype none
module hcm26_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [hcm26_pkg::LETTER_W-1:0] letter_in_i,
  input  wire logic                          full_i,
  output hcm26_pkg::grp_xfer_t               push_o
);

  localparam logic [1:0] LAST_IDX = 2'(hcm26_pkg::MATRIX_ORDER - 1);

  logic [1:0]                    cnt_q, cnt_d;
  logic [hcm26_pkg::LETTER_W-1:0] pend_q [2];
  logic [hcm26_pkg::LETTER_W-1:0] pend_d [2];
  logic [hcm26_pkg::LETTER_W-1:0] letter;
  logic                          accept;

  assign in_stall_o = (cnt_q == LAST_IDX) && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign letter     = hcm26_pkg::red5(letter_in_i);

  always_comb begin
    cnt_d  = cnt_q;
    pend_d = pend_q;
    push_o.valid = accept && (cnt_q == LAST_IDX);
    push_o.data  = {letter, pend_q[1], pend_q[0]};
    if (accept) begin
      if (cnt_q == LAST_IDX) begin
        cnt_d = '0;
      end else begin
        pend_d[cnt_q[0]] = letter;
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      pend_q[0] <= '0;
      pend_q[1] <= '0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/hcm26_fifo.sv
`default_nettype none
module hcm26_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire hcm26_pkg::grp_xfer_t push_i,
  output logic                      full_o,
  output hcm26_pkg::grp_xfer_t      head_o,
  input  wire logic                 pop_i
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hcm26_pkg::trigraph_t mem_q [DEPTH];
  logic [AW-1:0]        wr_q, rd_q;
  logic [CW-1:0]        cnt_q;
  logic                 do_push, do_pop;

  assign full_o      = (cnt_q == CW'(DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      if (do_pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule
`default_nettype wire

// File: hdl/hcm26_back.sv
`default_nettype none
module hcm26_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire hcm26_pkg::cfg_t                cfg_i,
  input  wire hcm26_pkg::grp_xfer_t           grp_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [hcm26_pkg::LETTER_W-1:0]      letter_out_o,
  output logic                                last_of_group_o,
  output logic                                key_error_o
);

  localparam int N  = hcm26_pkg::MATRIX_ORDER;
  localparam int LW = hcm26_pkg::LETTER_W;
  localparam int PW = hcm26_pkg::PROD_W;
  localparam int SW = hcm26_pkg::SUM_W;
  localparam logic [1:0] LAST_ROW = 2'(N - 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MUL_COF = 4'd1;
  localparam logic [3:0] ST_RED_COF = 4'd2;
  localparam logic [3:0] ST_MUL_DET = 4'd3;
  localparam logic [3:0] ST_RED_DET = 4'd4;
  localparam logic [3:0] ST_MUL_DOT = 4'd5;
  localparam logic [3:0] ST_RED_DOT = 4'd6;
  localparam logic [3:0] ST_MUL_SCL = 4'd7;
  localparam logic [3:0] ST_RED_SCL = 4'd8;
  localparam logic [3:0] ST_EMIT    = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [1:0]    row_q, row_d;
  logic [PW-1:0] pa_q [N*N];
  logic [PW-1:0] pa_d [N*N];
  logic [PW-1:0] pb_q [N*N];
  logic [PW-1:0] pb_d [N*N];
  logic [LW-1:0] cof_q [N*N];
  logic [LW-1:0] cof_d [N*N];
  logic [LW-1:0] s_q [N];
  logic [LW-1:0] s_d [N];
  logic [LW-1:0] dinv_q, dinv_d;
  logic          err_q, err_d;
  logic          out_valid_q, out_valid_d;
  logic [LW-1:0] letter_q, letter_d;
  logic          last_q, last_d;
  logic          kerr_q, kerr_d;

  logic [LW-1:0] km [N][N];
  logic [LW-1:0] coef [N][N];
  logic [LW-1:0] det;
  logic          out_load;

  always_comb begin
    for (int r = 0; r < N; r++) begin
      for (int c = 0; c < N; c++) begin
        km[r][c]   = hcm26_pkg::red5(cfg_i.key[LW*(N*r+c) +: LW]);
        coef[r][c] = cfg_i.dir ? cof_q[N*c+r] : km[r][c];
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign letter_out_o    = letter_q;
  assign last_of_group_o = last_q;
  assign key_error_o     = kerr_q;

  always_comb begin
    int r1, r2, c1, c2;
    r1       = 0;
    r2       = 0;
    c1       = 0;
    c2       = 0;
    state_d  = state_q;
    row_d    = row_q;
    pa_d     = pa_q;
    pb_d     = pb_q;
    cof_d    = cof_q;
    s_d      = s_q;
    dinv_d   = dinv_q;
    err_d    = err_q;
    letter_d = letter_q;
    last_d   = last_q;
    kerr_d   = kerr_q;
    pop_o    = 1'b0;
    out_load = 1'b0;
    det      = hcm26_pkg::mod26({1'b0, pa_q[0]} + {1'b0, pa_q[1]} + {1'b0, pa_q[2]});
    unique case (state_q)
      ST_IDLE: begin
        if (grp_i.valid) begin
          err_d   = 1'b0;
          state_d = cfg_i.dir ? ST_MUL_COF : ST_MUL_DOT;
        end
      end
      ST_MUL_COF: begin
        for (int r = 0; r < N; r++) begin
          for (int c = 0; c < N; c++) begin
            r1 = (r == N - 1) ? 0 : r + 1;
            r2 = (r == 0) ? N - 1 : r - 1;
            c1 = (c == N - 1) ? 0 : c + 1;
            c2 = (c == 0) ? N - 1 : c - 1;
            pa_d[N*r+c] = hcm26_pkg::mul5(km[r1][c1], km[r2][c2]);
            pb_d[N*r+c] = hcm26_pkg::mul5(km[r1][c2], km[r2][c1]);
          end
        end
        state_d = ST_RED_COF;
      end
      ST_RED_COF: begin
        for (int i = 0; i < N*N; i++) begin
          cof_d[i] = hcm26_pkg::mod26({1'b0, pa_q[i]} + hcm26_pkg::COF_OFFSET
                                      - {1'b0, pb_q[i]});
        end
        state_d = ST_MUL_DET;
      end
      ST_MUL_DET: begin
        for (int c = 0; c < N; c++) pa_d[c] = hcm26_pkg::mul5(km[0][c], cof_q[c]);
        state_d = ST_RED_DET;
      end
      ST_RED_DET: begin
        dinv_d  = hcm26_pkg::inv26(det);
        err_d   = (hcm26_pkg::inv26(det) == '0);
        state_d = ST_MUL_DOT;
      end
      ST_MUL_DOT: begin
        for (int r = 0; r < N; r++) begin
          for (int k = 0; k < N; k++) begin
            pa_d[N*r+k] = hcm26_pkg::mul5(coef[r][k], grp_i.data[k]);
          end
        end
        state_d = ST_RED_DOT;
      end
      ST_RED_DOT: begin
        for (int r = 0; r < N; r++) begin
          s_d[r] = hcm26_pkg::mod26({1'b0, pa_q[N*r]} + {1'b0, pa_q[N*r+1]}
                                    + {1'b0, pa_q[N*r+2]});
        end
        row_d   = '0;
        state_d = cfg_i.dir ? ST_MUL_SCL : ST_EMIT;
      end
      ST_MUL_SCL: begin
        for (int r = 0; r < N; r++) pa_d[r] = hcm26_pkg::mul5(dinv_q, s_q[r]);
        state_d = ST_RED_SCL;
      end
      ST_RED_SCL: begin
        for (int r = 0; r < N; r++) s_d[r] = hcm26_pkg::mod26(SW'(pa_q[r]));
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          letter_d = err_q ? '0 : s_q[row_q];
          last_d   = (row_q == LAST_ROW);
          kerr_d   = err_q;
          if (row_q == LAST_ROW) begin
            pop_o   = 1'b1;
            row_d   = '0;
            state_d = ST_IDLE;
          end else begin
            row_d = row_q + 2'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    cof_q    <= cof_d;
    s_q      <= s_d;
    dinv_q   <= dinv_d;
    letter_q <= letter_d;
    last_q   <= last_d;
    kerr_q   <= kerr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/hill_cipher_3x3_mod26_core.sv
// Hill cipher, order 3, mod 26.
// Input channel: in_valid_i / in_stall_o carry one letter code per transaction.
// Codes 26..31 are reduced mod 26. Every third letter closes a group.
// Output channel: out_valid_o / out_stall_i carry three letters per group,
// last_of_group_o set on the third; key_error_o set (letters zero) when
// decrypting with a key whose determinant has no inverse mod 26.
// Config channel: cfg_valid_i / cfg_ready_o, index 0 key matrix, index 1
// direction (0 encrypt, 1 decrypt). Ready is always high; write only when idle.
// Steps: encrypting runs the dot-product multiply and reduce, then emits;
// decrypting adds cofactor and determinant steps before and scaling steps after
// it, on the shared back-end sequencer. Results then leave one per cycle unless
// the output stalls; a group leaves the queue when its last letter is emitted.
// A QUEUE_DEPTH group queue lets letters keep arriving while the back end
// works; in_stall_o rises only on a closing letter with the queue full.
// A stall on the output holds the output register and the sequencer.
// Reset: empty queue, no open group, key reset value, encrypt direction.
`default_nettype none
module hill_cipher_3x3_mod26_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [hcm26_pkg::LETTER_W-1:0]     letter_in_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [hcm26_pkg::LETTER_W-1:0]          letter_out_o,
  output logic                                    last_of_group_o,
  output logic                                    key_error_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [0:0]                         cfg_index_i,
  input  wire logic [hcm26_pkg::KEY_W-1:0]        cfg_data_i
);

  logic [hcm26_pkg::KEY_W-1:0] key_q;
  logic                        dir_q;
  hcm26_pkg::cfg_t             cfg;
  hcm26_pkg::grp_xfer_t        push, head;
  logic                        full, pop;

  assign cfg_ready_o = 1'b1;
  assign cfg.key     = key_q;
  assign cfg.dir     = dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= hcm26_pkg::KEY_RESET;
      dir_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (hcm26_pkg::cfg_index_e'(cfg_index_i))
        hcm26_pkg::CFG_KEY_MATRIX: key_q <= cfg_data_i;
        hcm26_pkg::CFG_DIRECTION:  dir_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  hcm26_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .letter_in_i (letter_in_i),
    .full_i      (full),
    .push_o      (push)
  );

  hcm26_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  hcm26_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .grp_i           (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .letter_out_o    (letter_out_o),
    .last_of_group_o (last_of_group_o),
    .key_error_o     (key_error_o)
  );

endmodule
`default_nettype wire

// File: tb/sv/hill_cipher_3x3_mod26_core_test.sv
`timescale 1ns / 1ps
module hill_cipher_3x3_mod26_core_test;

  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 90;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 8;
  localparam int KW             = hcm26_pkg::KEY_W;
  localparam int LW             = hcm26_pkg::LETTER_W;
  localparam int AS             = hcm26_pkg::ALPHABET_SIZE;
  localparam int MO             = hcm26_pkg::MATRIX_ORDER;

  localparam logic [KW-1:0] KEY_ALL_ONES = {KW{1'b1}};
  localparam logic [KW-1:0] KEY_IDENTITY = (45'd1 << 40) | (45'd1 << 20) | 45'd1;

  typedef struct packed {
    logic [LW-1:0] letter;
    logic          last;
    logic          err;
  } letter_result_t;

  typedef struct packed {
    logic                  is_write;
    hcm26_pkg::cfg_index_e idx;
    logic [KW-1:0]         data;
    logic [LW-1:0]         letter;
    logic                  typed;
    letter_result_t        exp;
  } stim_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic [LW-1:0] letter_in_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [LW-1:0] letter_out_o;
  logic          last_of_group_o;
  logic          key_error_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [0:0]    cfg_index_i;
  logic [KW-1:0] cfg_data_i;

  hill_cipher_3x3_mod26_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .letter_in_i    (letter_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .letter_out_o   (letter_out_o),
    .last_of_group_o(last_of_group_o),
    .key_error_o    (key_error_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // predictor state
  logic [KW-1:0]    key_shadow = hcm26_pkg::KEY_RESET;
  logic             dir_shadow = 1'b0;
  int               held_letter[2];
  logic             held_typed[2];
  letter_result_t   held_exp[2];
  int               open_count = 0;
  letter_result_t   cipher_q[$];

  // typed expectation of the letter currently offered
  logic             row_typed = 1'b0;
  letter_result_t   row_exp = '0;

  stim_row_t        directed[$];
  logic             hold_req = 1'b0;
  logic             quiet = 1'b0;
  int               errors = 0;
  int               letters_seen = 0;
  int               results_checked = 0;
  int               bad_key_results = 0;
  int               stall_cycles = 0;
  int               idle_cycles = 0;

  function automatic int key_entry(logic [KW-1:0] key, int r, int c);
    return int'(key[5*(3*r+c) +: 5]) % AS;
  endfunction

  function automatic int cofactor(logic [KW-1:0] key, int r, int c);
    int r1, r2, c1, c2;
    r1 = (r + 1) % MO;
    r2 = (r + 2) % MO;
    c1 = (c + 1) % MO;
    c2 = (c + 2) % MO;
    return (key_entry(key, r1, c1) * key_entry(key, r2, c2) + AS * AS
            - key_entry(key, r1, c2) * key_entry(key, r2, c1)) % AS;
  endfunction

  function automatic int inverse_mod26(int v);
    int x;
    for (x = 1; x < AS; x++) begin
      if ((v * x) % AS == 1) return x;
    end
    return 0;
  endfunction

  function automatic void take_letter(logic [LW-1:0] raw);
    int             vec[3];
    int             det, dinv, acc, coef, r, k;
    logic           bad;
    logic           all_typed;
    letter_result_t res;
    vec[2] = int'(raw) % AS;
    if (open_count < 2) begin
      held_letter[open_count] = vec[2];
      held_typed[open_count] = row_typed;
      held_exp[open_count] = row_exp;
      open_count++;
      return;
    end
    open_count = 0;
    vec[0] = held_letter[0];
    vec[1] = held_letter[1];
    all_typed = held_typed[0] && held_typed[1] && row_typed;
    bad = 1'b0;
    dinv = 0;
    if (dir_shadow) begin
      det = 0;
      for (k = 0; k < MO; k++)
        det = (det + key_entry(key_shadow, 0, k) * cofactor(key_shadow, 0, k)) % AS;
      dinv = inverse_mod26(det);
      bad = (dinv == 0);
    end
    for (r = 0; r < MO; r++) begin
      acc = 0;
      for (k = 0; k < MO; k++) begin
        if (dir_shadow) coef = (dinv * cofactor(key_shadow, k, r)) % AS;
        else coef = key_entry(key_shadow, r, k);
        acc += coef * vec[k];
      end
      res.letter = bad ? '0 : LW'(acc % AS);
      res.last = (r == MO - 1);
      res.err = bad;
      if (all_typed) res = (r == 2) ? row_exp : held_exp[r];
      cipher_q.push_back(res);
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (hcm26_pkg::cfg_index_e'(cfg_index_i))
          hcm26_pkg::CFG_KEY_MATRIX: key_shadow = cfg_data_i;
          hcm26_pkg::CFG_DIRECTION:  dir_shadow = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        letters_seen++;
        take_letter(letter_in_i);
      end
      if (in_valid_i && in_stall_o) stall_cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (cipher_q.size() == 0) begin
          $error("unexpected result: letter_out %0d last_of_group %0b key_error %0b",
                 letter_out_o, last_of_group_o, key_error_o);
          errors++;
        end else begin
          letter_result_t want;
          want = cipher_q.pop_front();
          results_checked++;
          if (key_error_o) bad_key_results++;
          if (letter_out_o !== want.letter) begin
            $error("letter_out: expected %0d, actual %0d", want.letter, letter_out_o);
            errors++;
          end
          if (last_of_group_o !== want.last) begin
            $error("last_of_group: expected %0b, actual %0b", want.last, last_of_group_o);
            errors++;
          end
          if (key_error_o !== want.err) begin
            $error("key_error: expected %0b, actual %0b", want.err, key_error_o);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output side: random stalls, none when quiet, or a counted hold-off when requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (quiet) begin
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = ($urandom_range(0, 99) < 24);
      end
    end
  end

  task automatic send_letter(input logic [LW-1:0] l, input logic typed,
                             input letter_result_t exp);
    while (!quiet && $urandom_range(0, 99) < 24) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    letter_in_i = l;
    row_typed = typed;
    row_exp = exp;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    @(negedge clk_i);
  endtask

  task automatic write_reg(input hcm26_pkg::cfg_index_e idx, input logic [KW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // wait out all pending letters and let the back end go quiet
  task automatic drain_block();
    in_valid_i = 1'b0;
    row_typed = 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic add_letter(input logic [LW-1:0] l);
    directed.push_back({1'b0, hcm26_pkg::CFG_KEY_MATRIX, {KW{1'b0}}, l, 1'b0, 7'b0});
  endtask

  task automatic add_write(input hcm26_pkg::cfg_index_e idx, input logic [KW-1:0] data);
    directed.push_back({1'b1, idx, data, {LW{1'b0}}, 1'b0, 7'b0});
  endtask

  task automatic add_typed_group(input logic [LW-1:0] l0, l1, l2,
                                 input logic [LW-1:0] e0, e1, e2, input logic err);
    directed.push_back({1'b0, hcm26_pkg::CFG_KEY_MATRIX, {KW{1'b0}}, l0, 1'b1,
                        {e0, 1'b0, err}});
    directed.push_back({1'b0, hcm26_pkg::CFG_KEY_MATRIX, {KW{1'b0}}, l1, 1'b1,
                        {e1, 1'b0, err}});
    directed.push_back({1'b0, hcm26_pkg::CFG_KEY_MATRIX, {KW{1'b0}}, l2, 1'b1,
                        {e2, 1'b1, err}});
  endtask

  initial begin
    stim_row_t     row;
    int            ph, n;
    logic [KW-1:0] key;
    logic          dir_bit;
    logic [LW-1:0] l;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    letter_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = hcm26_pkg::CFG_KEY_MATRIX;
    cfg_data_i = '0;

    add_typed_group(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 1'b0);
    add_typed_group(5'd27, 5'd26, 5'd26, 5'd17, 5'd21, 5'd2, 1'b0);
    add_write(hcm26_pkg::CFG_DIRECTION, 45'd1);
    add_typed_group(5'd17, 5'd21, 5'd2, 5'd1, 5'd0, 5'd0, 1'b0);
    add_letter(5'd5);
    add_write(hcm26_pkg::CFG_DIRECTION, 45'd0);
    add_letter(5'd9);
    add_letter(5'd30);
    add_write(hcm26_pkg::CFG_KEY_MATRIX, '0);
    add_typed_group(5'd7, 5'd19, 5'd25, 5'd0, 5'd0, 5'd0, 1'b0);
    add_write(hcm26_pkg::CFG_DIRECTION, KEY_ALL_ONES);
    add_typed_group(5'd3, 5'd4, 5'd5, 5'd0, 5'd0, 5'd0, 1'b1);
    add_write(hcm26_pkg::CFG_KEY_MATRIX, KEY_ALL_ONES);
    add_typed_group(5'd25, 5'd0, 5'd13, 5'd0, 5'd0, 5'd0, 1'b1);
    add_write(hcm26_pkg::CFG_KEY_MATRIX, KEY_IDENTITY);
    add_typed_group(5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 1'b0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      row = directed[i];
      if (row.is_write) begin
        drain_block();
        write_reg(row.idx, row.data);
      end else begin
        send_letter(row.letter, row.typed, row.exp);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      drain_block();
      case (ph)
        0: key = hcm26_pkg::KEY_RESET;
        1: key = KEY_ALL_ONES;
        2: key = '0;
        default: key = KW'({$urandom(), $urandom()});
      endcase
      write_reg(hcm26_pkg::CFG_KEY_MATRIX, key);
      dir_bit = (ph == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      write_reg(hcm26_pkg::CFG_DIRECTION, {(KW-1)'($urandom()), dir_bit});
      quiet = (ph == 5);
      if (ph == 3) hold_req = 1'b1;
      n = $urandom_range(21, 29);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) l = LW'($urandom_range(26, 31));
        else l = LW'($urandom_range(0, 25));
        send_letter(l, 1'b0, '0);
      end
    end
    quiet = 1'b0;
    drain_block();

    $display("Sent %0d letters over %0d key/direction settings, checked %0d output letters",
             letters_seen, PHASES + 6, results_checked);
    $display("%0d letters flagged for a singular key, input held off for %0d cycles",
             bad_key_results, stall_cycles);
    if (errors == 0 && cipher_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/hcm26_pkg.sv
hdl/hcm26_front.sv
hdl/hcm26_fifo.sv
hdl/hcm26_back.sv
hdl/hill_cipher_3x3_mod26_core.sv
tb/sv/hill_cipher_3x3_mod26_core_test.sv
